### hdl/pll_pkg.sv
// Package for the piecewise-linear lookup block: request and result payloads,
// register indexes, pipeline control bits and shared widths.
// No dependencies.
`default_nettype none

package pll_pkg;

	localparam int MAX_POINTS_DEF = 4;
	localparam int VALUE_BITS_DEF = 16;
	localparam int X_BITS = 16;
	localparam int ENTRY_BITS = 16;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_INDEX_BITS = 2;
	localparam int COUNT_BITS = 3;
	localparam int DIV_STEPS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_POINT_COUNT      = 2'd0,
		REG_BREAKPOINT_X     = 2'd1,
		REG_BREAKPOINT_ERROR = 2'd2
	} pll_reg_t;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_FIRST  = 2'd1,
		MODE_LAST   = 2'd2,
		MODE_INTERP = 2'd3
	} pll_mode_t;

	typedef struct packed {
		logic signed [X_BITS-1:0] x_value;
		logic                     x_missing;
	} pll_sample_t;

	typedef struct packed {
		logic [ENTRY_BITS-1:0] error_value;
		logic                  error_missing;
	} pll_result_t;

	typedef struct packed {
		logic missing;
		logic interp;
		logic neg;
	} pll_ctrl_t;

endpackage

`default_nettype wire

### hdl/pll_config.sv
// Configuration registers of the lookup block and the decoded breakpoint table.
// Depends on pll_pkg.
`default_nettype none

module pll_config
	import pll_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic [COUNT_BITS-1:0]          point_num,
	output logic signed [X_BITS-1:0]       bp_x [MAX_POINTS],
	output logic [VALUE_BITS-1:0]          bp_err [MAX_POINTS]
);

	localparam int SHIFT = ENTRY_BITS - VALUE_BITS;

	logic [COUNT_BITS-1:0]    count_q;
	logic [CFG_DATA_BITS-1:0] x_q;
	logic [CFG_DATA_BITS-1:0] err_q;
	logic [ENTRY_BITS-1:0]    x_sh [MAX_POINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_BITS'(2);
			x_q     <= '0;
			err_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINT_COUNT:      count_q <= cfg_data[COUNT_BITS-1:0];
				REG_BREAKPOINT_X:     x_q <= cfg_data;
				REG_BREAKPOINT_ERROR: err_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_q < COUNT_BITS'(2)) begin
			point_num = COUNT_BITS'(2);
		end else if (count_q > COUNT_BITS'(MAX_POINTS)) begin
			point_num = COUNT_BITS'(MAX_POINTS);
		end else begin
			point_num = count_q;
		end
	end

	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_entry
		assign x_sh[k]   = x_q[k*ENTRY_BITS +: ENTRY_BITS] << SHIFT;
		assign bp_x[k]   = $signed(x_sh[k]) >>> SHIFT;
		assign bp_err[k] = err_q[k*ENTRY_BITS +: VALUE_BITS];
	end

endmodule

`default_nettype wire

### hdl/pll_segment.sv
// Front pipeline of the lookup block: segment search, segment differences and
// the numerator product, in three register stages.
// Depends on pll_pkg.
`default_nettype none

module pll_segment
	import pll_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire pll_sample_t                      sample,
	input  wire logic [COUNT_BITS-1:0]            point_num,
	input  wire logic signed [X_BITS-1:0]         bp_x [MAX_POINTS],
	input  wire logic [VALUE_BITS-1:0]            bp_err [MAX_POINTS],
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output pll_ctrl_t                             out_ctrl,
	output logic [X_BITS+VALUE_BITS-1:0]          out_prod,
	output logic [X_BITS-1:0]                     out_den,
	output logic [VALUE_BITS-1:0]                 out_base
);

	localparam int SEG_BITS  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int PROD_BITS = X_BITS + VALUE_BITS;

	logic en1, en2, en3;

	logic [SEG_BITS-1:0]      last_idx;
	logic signed [X_BITS-1:0] first_x, last_x;
	logic                     ascending, at_first, at_last, any_hit;
	logic [SEG_BITS-1:0]      hit_seg;
	pll_mode_t                mode;

	logic                     v_s1;
	logic signed [X_BITS-1:0] x_s1;
	logic                     miss_s1;
	pll_mode_t                mode_s1;
	logic [SEG_BITS-1:0]      seg_s1;

	logic [SEG_BITS-1:0]        lo_idx;
	logic signed [X_BITS-1:0]   x0, x1;
	logic [VALUE_BITS-1:0]      y0, y1;
	logic signed [X_BITS:0]     dx, den;
	logic signed [VALUE_BITS:0] dy;
	logic [VALUE_BITS-1:0]      base;
	pll_ctrl_t                  ctrl2;

	logic                  v_s2;
	pll_ctrl_t             ctrl_s2;
	logic [X_BITS-1:0]     dxm_s2;
	logic [X_BITS-1:0]     den_s2;
	logic [VALUE_BITS-1:0] dym_s2;
	logic [VALUE_BITS-1:0] base_s2;

	logic                  v_s3;
	pll_ctrl_t             ctrl_s3;
	logic [PROD_BITS-1:0]  prod_s3;
	logic [X_BITS-1:0]     den_s3;
	logic [VALUE_BITS-1:0] base_s3;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// Stage 1: end clamps and the first segment that holds the sample.
	assign last_idx  = SEG_BITS'(point_num - COUNT_BITS'(1));
	assign first_x   = bp_x[0];
	assign last_x    = bp_x[last_idx];
	assign ascending = !(last_x < first_x);
	assign at_first  = ascending ? (sample.x_value <= first_x) : (sample.x_value >= first_x);
	assign at_last   = ascending ? (sample.x_value >= last_x) : (sample.x_value <= last_x);

	always_comb begin
		hit_seg = '0;
		any_hit = 1'b0;
		for (int k = MAX_POINTS - 1; k >= 1; k--) begin
			if (k < int'(point_num) && (ascending ?
					(sample.x_value > bp_x[k-1] && sample.x_value <= bp_x[k]) :
					(sample.x_value < bp_x[k-1] && sample.x_value >= bp_x[k]))) begin
				hit_seg = SEG_BITS'(k);
				any_hit = 1'b1;
			end
		end
	end

	always_comb begin
		if (at_first) begin
			mode = MODE_FIRST;
		end else if (at_last) begin
			mode = MODE_LAST;
		end else if (any_hit) begin
			mode = MODE_INTERP;
		end else begin
			mode = MODE_NONE;
		end
	end

	// Stage 2: segment end points, differences and their magnitudes.
	assign lo_idx = seg_s1 - SEG_BITS'(1);
	assign x0     = bp_x[lo_idx];
	assign x1     = bp_x[seg_s1];
	assign y0     = bp_err[lo_idx];
	assign y1     = bp_err[seg_s1];
	assign dx     = $signed({x_s1[X_BITS-1], x_s1}) - $signed({x0[X_BITS-1], x0});
	assign den    = $signed({x1[X_BITS-1], x1}) - $signed({x0[X_BITS-1], x0});
	assign dy     = $signed({1'b0, y1}) - $signed({1'b0, y0});

	always_comb begin
		case (mode_s1)
			MODE_FIRST:  base = bp_err[0];
			MODE_LAST:   base = bp_err[last_idx];
			MODE_INTERP: base = y0;
			default:     base = '0;
		endcase
	end

	assign ctrl2.missing = miss_s1;
	assign ctrl2.interp  = (mode_s1 == MODE_INTERP);
	assign ctrl2.neg     = dy[VALUE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1    <= sample.x_value;
			miss_s1 <= sample.x_missing;
			mode_s1 <= mode;
			seg_s1  <= hit_seg;
		end
		if (en2) begin
			ctrl_s2 <= ctrl2;
			dxm_s2  <= dx[X_BITS] ? X_BITS'(-dx) : X_BITS'(dx);
			den_s2  <= den[X_BITS] ? X_BITS'(-den) : X_BITS'(den);
			dym_s2  <= dy[VALUE_BITS] ? VALUE_BITS'(-dy) : VALUE_BITS'(dy);
			base_s2 <= base;
		end
		if (en3) begin
			ctrl_s3 <= ctrl_s2;
			prod_s3 <= PROD_BITS'(dxm_s2) * PROD_BITS'(dym_s2);
			den_s3  <= den_s2;
			base_s3 <= base_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_ctrl  = ctrl_s3;
	assign out_prod  = prod_s3;
	assign out_den   = den_s3;
	assign out_base  = base_s3;

`ifndef ASSERT_OFF
	a_interp_segment: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && mode_s1 == MODE_INTERP |-> seg_s1 != '0)
		else $error("Interpolating request selected segment zero.");
`endif

endmodule

`default_nettype wire

### hdl/pll_divider.sv
// Pipelined restoring divider of the lookup block: the product magnitude over
// the segment width, two quotient bits per register stage.
// Depends on pll_pkg.
`default_nettype none

module pll_divider
	import pll_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire pll_ctrl_t                    in_ctrl,
	input  wire logic [X_BITS+VALUE_BITS-1:0] in_prod,
	input  wire logic [X_BITS-1:0]            in_den,
	input  wire logic [VALUE_BITS-1:0]        in_base,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output pll_ctrl_t                         out_ctrl,
	output logic [VALUE_BITS-1:0]             out_quo,
	output logic [VALUE_BITS-1:0]             out_base
);

	localparam int ZW         = X_BITS + VALUE_BITS;
	localparam int DIV_STAGES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;

	logic [DIV_STAGES-1:0] v_s;
	logic [DIV_STAGES-1:0] en;
	logic [ZW-1:0]         z_s    [DIV_STAGES];
	logic [X_BITS-1:0]     den_s  [DIV_STAGES];
	logic [VALUE_BITS-1:0] base_s [DIV_STAGES];
	pll_ctrl_t             ctrl_s [DIV_STAGES];
	logic [ZW-1:0]         z_next [DIV_STAGES];

	always_comb begin
		en[DIV_STAGES-1] = !v_s[DIV_STAGES-1] || out_ready;
		for (int s = DIV_STAGES - 2; s >= 0; s--) begin
			en[s] = !v_s[s] || en[s+1];
		end
	end

	assign in_ready = en[0];

	// The remainder sits in the upper bits of the working word and quotient
	// bits shift in at the bottom.
	always_comb begin
		logic [ZW-1:0]     z_w;
		logic [X_BITS-1:0] d_w;
		logic [X_BITS:0]   tr;
		logic              qbit;
		for (int s = 0; s < DIV_STAGES; s++) begin
			if (s == 0) begin
				z_w = in_prod;
				d_w = in_den;
			end else begin
				z_w = z_s[s-1];
				d_w = den_s[s-1];
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				tr   = {z_w[ZW-1:VALUE_BITS], z_w[VALUE_BITS-1]};
				qbit = (tr >= {1'b0, d_w});
				if (qbit) begin
					tr = tr - {1'b0, d_w};
				end
				if (s * DIV_STEPS + j < VALUE_BITS) begin
					z_w = {tr[X_BITS-1:0], z_w[VALUE_BITS-2:0], qbit};
				end
			end
			z_next[s] = z_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int s = 0; s < DIV_STAGES; s++) begin
				if (en[s]) begin
					v_s[s] <= (s == 0) ? in_valid : v_s[s-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < DIV_STAGES; s++) begin
			if (en[s]) begin
				z_s[s] <= z_next[s];
				if (s == 0) begin
					den_s[s]  <= in_den;
					base_s[s] <= in_base;
					ctrl_s[s] <= in_ctrl;
				end else begin
					den_s[s]  <= den_s[s-1];
					base_s[s] <= base_s[s-1];
					ctrl_s[s] <= ctrl_s[s-1];
				end
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign out_ctrl  = ctrl_s[DIV_STAGES-1];
	assign out_quo   = z_s[DIV_STAGES-1][VALUE_BITS-1:0];
	assign out_base  = base_s[DIV_STAGES-1];

`ifndef ASSERT_OFF
	a_chain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("Divider stalled its input while its output side was ready.");
`endif

endmodule

`default_nettype wire

### hdl/piecewise_linear_lookup.sv
// Piecewise-linear error lookup: a streaming evaluator of a 2 to 4 point table.
// Top level; depends on pll_pkg, pll_config, pll_segment and pll_divider.
//
// Use: samples enter on the sample channel (valid/ready); each sample gives
// exactly one result on the result channel, in order. The table must be loaded
// by the user through the write port (cfg_we, cfg_index, cfg_data) while no
// request is in flight; the block itself does not enforce this. Index 0 is the
// point count, 1 packed breakpoint x values, 2 packed error values. A sample at
// or beyond an end of the table returns that end's error; inside, the segment
// is interpolated with the quotient truncated toward zero. A missing sample
// returns a missing result with value zero. The pipeline holds 3 front stages
// (segment search, differences, product), then ceil(VALUE_BITS / 2) divider
// stages, then the output register. The divider's two quotient bits per stage
// set that depth. Throughput is one request per cycle while the receiver takes
// results, since every stage is a register that takes a new request each
// cycle. Each stage moves when its successor has room, so a stalled receiver
// holds the result register and bubbles upstream still close up. Reset empties
// the pipeline and loads a two-point table of zeros.
`default_nettype none

module piecewise_linear_lookup
	import pll_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      sample_valid,
	output logic                           sample_ready,
	input  wire pll_sample_t               sample,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output pll_result_t                    result
);

	logic [COUNT_BITS-1:0]    point_num;
	logic signed [X_BITS-1:0] bp_x [MAX_POINTS];
	logic [VALUE_BITS-1:0]    bp_err [MAX_POINTS];

	logic                         f_valid, f_ready;
	pll_ctrl_t                    f_ctrl;
	logic [X_BITS+VALUE_BITS-1:0] f_prod;
	logic [X_BITS-1:0]            f_den;
	logic [VALUE_BITS-1:0]        f_base;

	logic                  d_valid, d_ready;
	pll_ctrl_t             d_ctrl;
	logic [VALUE_BITS-1:0] d_quo;
	logic [VALUE_BITS-1:0] d_base;

	logic                  out_en;
	logic [VALUE_BITS-1:0] q;
	logic [VALUE_BITS-1:0] sum;
	logic                  result_valid_q;
	pll_result_t           result_q;

	pll_config #(
		.MAX_POINTS(MAX_POINTS),
		.VALUE_BITS(VALUE_BITS)
	) u_config (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.point_num(point_num),
		.bp_x     (bp_x),
		.bp_err   (bp_err)
	);

	pll_segment #(
		.MAX_POINTS(MAX_POINTS),
		.VALUE_BITS(VALUE_BITS)
	) u_segment (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_valid),
		.in_ready (sample_ready),
		.sample   (sample),
		.point_num(point_num),
		.bp_x     (bp_x),
		.bp_err   (bp_err),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_ctrl (f_ctrl),
		.out_prod (f_prod),
		.out_den  (f_den),
		.out_base (f_base)
	);

	pll_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_ctrl  (f_ctrl),
		.in_prod  (f_prod),
		.in_den   (f_den),
		.in_base  (f_base),
		.out_valid(d_valid),
		.out_ready(d_ready),
		.out_ctrl (d_ctrl),
		.out_quo  (d_quo),
		.out_base (d_base)
	);

	assign out_en  = !result_valid_q || result_ready;
	assign d_ready = out_en;

	// The quotient never exceeds the segment's error step, so the sum stays
	// between the two end values.
	assign q   = d_ctrl.interp ? d_quo : '0;
	assign sum = d_ctrl.neg ? (d_base - q) : (d_base + q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_en) begin
			result_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			result_q.error_missing <= d_ctrl.missing;
			result_q.error_value   <= d_ctrl.missing ? '0 : ENTRY_BITS'(sum);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("Sample channel stalled with an empty result register.");
`endif

endmodule

`default_nettype wire

### verif/tb_piecewise_linear_lookup.sv
// Testbench for piecewise_linear_lookup: directed and random samples against
// a scoreboard that predicts each interpolated error. Depends on pll_pkg.
`timescale 1ns / 1ps

module tb_piecewise_linear_lookup;
	import pll_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES = 9;
	localparam int PHASE_SAMPLES = 137;

	class error_lookup_board;
		logic [COUNT_BITS-1:0]    count;
		logic [CFG_DATA_BITS-1:0] table_x;
		logic [CFG_DATA_BITS-1:0] table_err;
		pll_result_t              expected_errors[$];
		int                       errors;

		function new();
			count = 3'd2;
			table_x = '0;
			table_err = '0;
			errors = 0;
		endfunction

		function void apply_write(logic [CFG_INDEX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_POINT_COUNT: count = data[COUNT_BITS-1:0];
				REG_BREAKPOINT_X: table_x = data;
				REG_BREAKPOINT_ERROR: table_err = data;
				default: ;
			endcase
		endfunction

		function longint entry_x(int k);
			return longint'($signed(table_x[ENTRY_BITS*k +: ENTRY_BITS]));
		endfunction

		function longint entry_err(int k);
			return longint'(table_err[ENTRY_BITS*k +: ENTRY_BITS]);
		endfunction

		function pll_result_t predict_error(pll_sample_t s);
			pll_result_t r;
			longint      xs, first, last, x0, x1, y0, y1, v;
			int          n;
			bit          asc;
			r.error_missing = s.x_missing;
			r.error_value = '0;
			if (s.x_missing) begin
				return r;
			end
			n = (count < 2) ? 2 : (count > 4) ? 4 : int'(count);
			xs = longint'($signed(s.x_value));
			first = entry_x(0);
			last = entry_x(n - 1);
			asc = !(last < first);
			v = 0;
			if ((asc && xs <= first) || (!asc && xs >= first)) begin
				v = entry_err(0);
			end else if ((asc && xs >= last) || (!asc && xs <= last)) begin
				v = entry_err(n - 1);
			end else begin
				for (int k = 1; k < n; k++) begin
					x0 = entry_x(k - 1);
					x1 = entry_x(k);
					if (asc ? (xs > x0 && xs <= x1) : (xs < x0 && xs >= x1)) begin
						y0 = entry_err(k - 1);
						y1 = entry_err(k);
						v = y0;
						if (x1 != x0) begin
							v = y0 + ((xs - x0) * (y1 - y0)) / (x1 - x0);
						end
						break;
					end
				end
			end
			if (v < 0) begin
				v = 0;
			end
			if (v > 65535) begin
				v = 65535;
			end
			r.error_value = v[ENTRY_BITS-1:0];
			return r;
		endfunction

		function void note_sample(pll_sample_t s);
			expected_errors.push_back(predict_error(s));
		endfunction

		function void check_error(pll_result_t r);
			pll_result_t e;
			if (expected_errors.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h/%b",
					$time, r.error_value, r.error_missing);
				errors++;
				return;
			end
			e = expected_errors.pop_front();
			if (r.error_value !== e.error_value) begin
				$display("%0t: error_value mismatch, expected %h, actual %h",
					$time, e.error_value, r.error_value);
				errors++;
			end
			if (r.error_missing !== e.error_missing) begin
				$display("%0t: error_missing mismatch, expected %b, actual %b",
					$time, e.error_missing, r.error_missing);
				errors++;
			end
		endfunction

		function int pending();
			return expected_errors.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      sample_valid;
	logic                      sample_ready;
	pll_sample_t               sample;
	logic                      result_valid;
	logic                      result_ready;
	pll_result_t               result;

	error_lookup_board sb;
	int                tx_idle_pct;
	int                rx_idle_pct;
	int                hold_left;
	int                cycle_count;

	piecewise_linear_lookup i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			sb.check_error(result);
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic [CFG_DATA_BITS-1:0] pack4(int a, int b, int c, int d);
		return {d[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.apply_write(idx, data);
	endtask

	task automatic load_table(input logic [COUNT_BITS-1:0] cnt,
		input logic [CFG_DATA_BITS-1:0] bx, input logic [CFG_DATA_BITS-1:0] be);
		logic [CFG_DATA_BITS-1:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_POINT_COUNT, {junk[CFG_DATA_BITS-1:COUNT_BITS], cnt});
		write_reg(REG_BREAKPOINT_X, bx);
		write_reg(REG_BREAKPOINT_ERROR, be);
		write_reg(REG_UNUSED, ~junk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(input int x, input bit miss);
		pll_sample_t s;
		s.x_value = x[15:0];
		s.x_missing = miss;
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		sb.note_sample(s);
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic pick_table(output logic [COUNT_BITS-1:0] cnt,
		output logic [CFG_DATA_BITS-1:0] bx, output logic [CFG_DATA_BITS-1:0] be);
		int xs[4];
		int ys[4];
		int r, style, t;
		r = $urandom_range(9);
		if (r < 7) begin
			cnt = 3'(2 + r % 3);
		end else if (r == 7) begin
			cnt = 3'($urandom_range(1));
		end else begin
			cnt = 3'($urandom_range(7, 5));
		end
		style = $urandom_range(9);
		for (int k = 0; k < 4; k++) begin
			xs[k] = int'($urandom_range(65535)) - 32768;
			ys[k] = $urandom_range(65535);
		end
		if (style == 7) begin
			xs = '{-32768, -1000, 1000, 32767};
			for (int k = 0; k < 4; k++) begin
				ys[k] = $urandom_range(1) ? 65535 : 0;
			end
		end else if (style <= 6) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3 - i; j++) begin
					if ((style <= 3) ? (xs[j] > xs[j+1]) : (xs[j] < xs[j+1])) begin
						t = xs[j];
						xs[j] = xs[j+1];
						xs[j+1] = t;
					end
				end
			end
		end else if (style == 9) begin
			xs[2] = xs[1];
		end
		bx = pack4(xs[0], xs[1], xs[2], xs[3]);
		be = pack4(ys[0], ys[1], ys[2], ys[3]);
	endtask

	function automatic int pick_x();
		int r, k, span, v;
		r = $urandom_range(15);
		if (r < 6) begin
			return int'($urandom_range(65535)) - 32768;
		end
		k = $urandom_range(3);
		span = (r < 11) ? 3 : 400;
		v = int'($signed(sb.table_x[ENTRY_BITS*k +: ENTRY_BITS]))
			+ int'($urandom_range(2 * span)) - span;
		if (v < -32768) begin
			v = -32768;
		end
		if (v > 32767) begin
			v = 32767;
		end
		return v;
	endfunction

	initial begin
		logic [COUNT_BITS-1:0]    cnt;
		logic [CFG_DATA_BITS-1:0] bx, be;
		sb = new();
		cycle_count = 0;
		hold_left = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_valid <= 1'b0;
		sample <= '0;
		result_ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_table(3'd4, pack4(-32768, -256, 512, 32767), pack4(0, 65535, 256, 32768));
		send_sample(-32768, 1'b0);
		send_sample(32767, 1'b0);
		send_sample(-256, 1'b0);
		send_sample(-255, 1'b0);
		send_sample(0, 1'b0);
		send_sample(512, 1'b0);
		send_sample(513, 1'b0);
		send_sample(20000, 1'b0);
		send_sample(32767, 1'b1);
		send_sample(-32768, 1'b1);
		wait_idle();

		load_table(3'd3, pack4(1000, 0, -1000, 0), pack4(10, 5000, 300, 0));
		send_sample(1000, 1'b0);
		send_sample(1001, 1'b0);
		send_sample(-1000, 1'b0);
		send_sample(-1001, 1'b0);
		send_sample(500, 1'b0);
		send_sample(0, 1'b0);
		send_sample(-500, 1'b0);
		wait_idle();

		load_table(3'd7, pack4(0, 0, 256, 256), pack4(1, 2, 3, 4));
		send_sample(0, 1'b0);
		send_sample(128, 1'b0);
		send_sample(256, 1'b0);
		send_sample(-1, 1'b0);
		wait_idle();

		load_table(3'd1, pack4(100, -100, 0, 0), pack4(65535, 0, 0, 0));
		send_sample(0, 1'b0);
		send_sample(200, 1'b0);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			tx_idle_pct = (p < 3) ? 38 : (p < 6) ? 66 : 0;
			rx_idle_pct = (p < 3) ? 66 : (p < 6) ? 38 : 0;
			pick_table(cnt, bx, be);
			load_table(cnt, bx, be);
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				if (p == 1 && i == 60) begin
					wait_idle();
				end
				if (p == 7 && i == 20) begin
					hold_left = 80;
				end
				send_sample(pick_x(), $urandom_range(7) == 0);
			end
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
